// ----- rtl/u2da_pkg.sv -----
`timescale 1ns / 1ps

package u2da_pkg;

    localparam int VALUE_W  = 32;
    localparam int N_DIGITS = 10;
    localparam int BCD_W    = 4 * N_DIGITS;
    localparam int STEP_W   = $clog2(VALUE_W);
    localparam int IDX_W    = $clog2(N_DIGITS);
    localparam int CHAR_W   = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_LOCATE,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic locate;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_last;
        logic idx_zero;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/u32_to_decimal_ascii.sv -----
`timescale 1ns / 1ps

// Unsigned 32-bit binary to decimal ASCII converter. Each input item is one
// number; the block returns its decimal digits as ASCII codes, most
// significant first, one digit per result item, without leading zeros (zero
// gives a single '0'), and marks the least significant digit with
// o_last_digit. An accepted item is converted by a shift-and-add-3 loop
// with one step per input bit, then the leading digit is located and the
// digits follow at up to one per cycle as the sink takes them. The output
// register holds the last digit of one number while the next number is
// accepted and converted.

module u32_to_decimal_ascii (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [u2da_pkg::VALUE_W-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [u2da_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                         o_last_digit
);
    import u2da_pkg::*;

    t_cmd cmd;
    t_sts sts;

    u2da_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    u2da_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_stall      (i_stall),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule

// ----- rtl/u2da_dp.sv -----
`timescale 1ns / 1ps

module u2da_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [u2da_pkg::VALUE_W-1:0] i_value,
    input  logic                         i_stall,
    input  u2da_pkg::t_cmd               i_cmd,
    output u2da_pkg::t_sts               o_sts,
    output logic                         o_valid,
    output logic [u2da_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                         o_last_digit
);
    import u2da_pkg::*;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [STEP_W-1:0]  r_cnt;
    logic [IDX_W-1:0]   r_idx;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_digit;
    logic               r_last;

    logic [BCD_W-1:0]   n_bcd_adj;
    logic [IDX_W-1:0]   n_lead;
    logic [3:0]         sel_digit;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < N_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_bcd_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                n_bcd_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // Most significant non-zero digit; zero gives the lowest digit.
    always_comb begin
        n_lead = '0;
        for (int i = 0; i < N_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                n_lead = IDX_W'(i);
            end
        end
    end

    assign sel_digit = r_bcd[{r_idx, 2'b00} +: 4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= i_value;
            r_bcd <= '0;
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_bcd <= {n_bcd_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_cnt <= r_cnt + STEP_W'(1);
        end
        if (i_cmd.locate) begin
            r_idx <= n_lead;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx - IDX_W'(1);
        end
        if (i_cmd.emit) begin
            r_digit <= ASCII_ZERO + {{(CHAR_W-4){1'b0}}, sel_digit};
            r_last  <= (r_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.step_last = (r_cnt == STEP_W'(VALUE_W - 1));
    assign o_sts.idx_zero  = (r_idx == '0);
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_digit;
    assign o_last_digit = r_last;

endmodule

// ----- rtl/u2da_ctrl.sv -----
`timescale 1ns / 1ps

module u2da_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  u2da_pkg::t_sts i_sts,
    output logic           o_stall,
    output u2da_pkg::t_cmd o_cmd
);
    import u2da_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                if (i_sts.step_last) begin
                    n_state = S_LOCATE;
                end
            end
            S_LOCATE: begin
                o_cmd.locate = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.idx_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/u2da_chk.sv -----
`timescale 1ns / 1ps

module u2da_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic [u2da_pkg::VALUE_W-1:0] i_value,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [u2da_pkg::CHAR_W-1:0]  o_digit_char,
    input logic                         o_last_digit
);
    import u2da_pkg::*;

    // A stalled result item must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digit_char) && $stable(o_last_digit))
        else $error("result item changed while stalled");

    // Every emitted character is a decimal digit.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_char >= ASCII_ZERO) && (o_digit_char <= ASCII_ZERO + CHAR_W'(9)))
        else $error("result character is not a decimal digit");

    // Once a number is taken, the block is busy converting it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after an item was accepted");

    // While a digit other than the last is on offer, the input stays stalled.
    a_busy_mid_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_digit |-> o_stall)
        else $error("input ready before the last digit was sent");

endmodule

bind u32_to_decimal_ascii u2da_chk u_chk (.*);
